/* hdl/sfr_pkg.sv */
// ----------------------------------------------------------------------------
// Sequenced fragment receiver package
// Shared widths, codes and payload types for the sequence check and the
// fragment reassembly control.
// ----------------------------------------------------------------------------
package sfr_pkg;

  // Field widths fixed by the datagram header format.
  localparam int SEQ_W  = 31;
  localparam int FILL_W = 17;
  localparam int OFF_W  = 15;
  localparam int LEN_W  = 11;
  localparam int MAX_W  = 16;
  localparam int CFG_W  = 16;

  // Configuration register indexes.
  localparam int CFG_IDX_W = 1;
  localparam logic [CFG_IDX_W-1:0] CFG_FRAG_SIZE = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_MSG   = 1'b1;

  // Configuration reset values.
  localparam logic [LEN_W-1:0] FRAG_SIZE_RST = 11'd1300;
  localparam logic [MAX_W-1:0] MAX_MSG_RST   = 16'd16384;

  // Verdict codes reported with every result.
  typedef enum logic [2:0] {
    VERDICT_WHOLE    = 3'd0,
    VERDICT_REASM    = 3'd1,
    VERDICT_STALE    = 3'd2,
    VERDICT_GAP      = 3'd3,
    VERDICT_BAD_LEN  = 3'd4,
    VERDICT_MORE     = 3'd5,
    VERDICT_TOO_LONG = 3'd6
  } verdict_t;

  // One parsed datagram header.
  typedef struct packed {
    logic [31:0]        header_word;
    logic signed [15:0] frag_start;
    logic signed [15:0] frag_len;
    logic [LEN_W-1:0]   payload_bytes;
  } hdr_t;

  // One result.
  typedef struct packed {
    verdict_t           verdict;
    logic [SEQ_W-1:0]   seq_number;
    logic [SEQ_W-1:0]   dropped_count;
    logic [OFF_W-1:0]   write_offset;
    logic [LEN_W-1:0]   copy_length;
    logic [OFF_W-1:0]   message_length;
  } res_t;

  // Sequence and reassembly state.
  typedef struct packed {
    logic [SEQ_W-1:0]  last_seq;
    logic [SEQ_W-1:0]  asm_seq;
    logic [FILL_W-1:0] fill;
  } state_t;

  // Configuration registers.
  typedef struct packed {
    logic [LEN_W-1:0] frag_size;
    logic [MAX_W-1:0] max_msg;
  } cfg_t;

endpackage

/* hdl/sfr_chan_if.sv */
// ----------------------------------------------------------------------------
// Sequenced fragment receiver channels
// Valid/ready interfaces for the header requests and the result requests.
// ----------------------------------------------------------------------------

// Header channel: one parsed datagram header per request.
interface sfr_hdr_if;
  logic        valid;
  logic        ready;
  logic [31:0] header_word;
  logic [15:0] frag_start;
  logic [15:0] frag_len;
  logic [10:0] payload_bytes;

  modport source (output valid, output header_word, output frag_start,
                  output frag_len, output payload_bytes, input ready);
  modport sink   (input valid, input header_word, input frag_start,
                  input frag_len, input payload_bytes, output ready);
endinterface

// Result channel: one verdict per header.
interface sfr_res_if;
  logic        valid;
  logic        ready;
  logic [2:0]  verdict;
  logic [30:0] seq_number;
  logic [30:0] dropped_count;
  logic [14:0] write_offset;
  logic [10:0] copy_length;
  logic [14:0] message_length;

  modport source (output valid, output verdict, output seq_number,
                  output dropped_count, output write_offset,
                  output copy_length, output message_length, input ready);
  modport sink   (input valid, input verdict, input seq_number,
                  input dropped_count, input write_offset,
                  input copy_length, input message_length, output ready);
endinterface

/* hdl/sfr_decide.sv */
// ----------------------------------------------------------------------------
// Sequenced fragment receiver decision logic
// Sequence check and reassembly bookkeeping for one header: produces the
// result and the next state from the current state and configuration.
// ----------------------------------------------------------------------------
module sfr_decide
  import sfr_pkg::*;
#(
  parameter int BUFFER_BYTES = 16384
) (
  input  hdr_t   hdr,
  input  state_t st,
  input  cfg_t   cfg,
  output res_t   res,
  output state_t st_nxt
);

  localparam logic [FILL_W:0] BufLimit = (FILL_W+1)'(BUFFER_BYTES);

  logic [SEQ_W-1:0]  seq;
  logic              frag;
  logic              stale;
  logic              restart;
  logic [FILL_W-1:0] fill_cur;
  logic [15:0]       len_u;
  logic [FILL_W:0]   sum;
  logic [FILL_W-1:0] new_fill;
  logic              start_ok;
  logic              len_bad;

  // Header decode and the compares that feed the verdict.
  always_comb begin
    seq      = hdr.header_word[SEQ_W-1:0];
    frag     = hdr.header_word[31];
    stale    = (seq <= st.last_seq);
    restart  = frag && !stale && (seq != st.asm_seq);
    fill_cur = restart ? '0 : st.fill;
    len_u    = hdr.frag_len;
    sum      = {1'b0, fill_cur} + {2'b00, len_u[15:0]};
    new_fill = sum[FILL_W-1:0];
    start_ok = !hdr.frag_start[15] && ({1'b0, hdr.frag_start} == fill_cur);
    len_bad  = hdr.frag_len[15] || (len_u > {5'b0, hdr.payload_bytes}) ||
               (sum > BufLimit);
  end

  // Verdict and state update.
  always_comb begin
    st_nxt             = st;
    res.verdict        = VERDICT_STALE;
    res.seq_number     = seq;
    res.dropped_count  = '0;
    res.write_offset   = '0;
    res.copy_length    = '0;
    res.message_length = '0;

    if (!stale) begin
      res.dropped_count = seq - st.last_seq - 31'd1;
      if (!frag) begin
        res.verdict = VERDICT_WHOLE;
        st_nxt.last_seq = seq;
      end else begin
        // A new fragment sequence restarts reassembly even if rejected.
        st_nxt.asm_seq = seq;
        st_nxt.fill    = fill_cur;
        if (!start_ok) begin
          res.verdict = VERDICT_GAP;
        end else if (len_bad) begin
          res.verdict = VERDICT_BAD_LEN;
        end else begin
          res.write_offset = fill_cur[OFF_W-1:0];
          res.copy_length  = len_u[LEN_W-1:0];
          st_nxt.fill      = new_fill;
          if (len_u == {5'b0, cfg.frag_size}) begin
            res.verdict = VERDICT_MORE;
          end else if (new_fill > {1'b0, cfg.max_msg}) begin
            res.verdict = VERDICT_TOO_LONG;
          end else begin
            res.verdict        = VERDICT_REASM;
            res.message_length = new_fill[OFF_W-1:0];
            st_nxt.fill        = '0;
            st_nxt.last_seq    = seq;
          end
        end
      end
    end
  end

endmodule

/* hdl/sequenced_fragment_receiver.sv */
// ----------------------------------------------------------------------------
// Sequenced fragment receiver
// Per-datagram sequence check and fragment reassembly control; the payload
// copy itself is done by an external DMA using the offset and length given.
// ----------------------------------------------------------------------------
//
//  Channel  Direction  Handshake      Contents
//  in_if    sink       valid/ready    parsed header (sequence word, fragment
//                                     start, fragment length, payload bytes)
//  out_if   source     valid/ready    verdict, sequence, dropped count,
//                                     write offset, copy length, length
//  cfg_*    sink       write enable   full fragment length, message limit
//
// One request is accepted every cycle while the result side takes results; each
// header passes through the input register, then the result register, before
// its result is valid on out_if.
// The decision for one header is combinational against the state
// registers, so consecutive headers see each other's updates directly.
// Reset is synchronous: the state clears and configuration takes defaults.
// While out_if.ready is low the result holds, at most one more header waits
// in the input register, and in_if.ready stays low while that register is full.
module sequenced_fragment_receiver
  import sfr_pkg::*;
#(
  parameter int BUFFER_BYTES = 16384
) (
  input  logic                 clk,
  input  logic                 rst_n,
  sfr_hdr_if.sink              in_if,
  sfr_res_if.source            out_if,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_data
);

  logic   in_valid_r, in_valid_nxt;
  hdr_t   in_hdr_r;
  logic   out_valid_r, out_valid_nxt;
  res_t   out_res_r;
  state_t st_r;
  state_t st_nxt;
  res_t   res_nxt;
  cfg_t   cfg_r;
  logic   in_accept;
  logic   advance;

  // Handshake control.
  assign advance   = in_valid_r && (!out_valid_r || out_if.ready);
  assign in_if.ready = !in_valid_r || advance;
  assign in_accept = in_if.valid && in_if.ready;

  always_comb begin
    in_valid_nxt  = in_accept ? 1'b1 : (advance ? 1'b0 : in_valid_r);
    out_valid_nxt = advance ? 1'b1 : (out_if.ready ? 1'b0 : out_valid_r);
  end

  // Decision logic between the input and result registers.
  sfr_decide #(
    .BUFFER_BYTES(BUFFER_BYTES)
  ) u_decide (
    .hdr    (in_hdr_r),
    .st     (st_r),
    .cfg    (cfg_r),
    .res    (res_nxt),
    .st_nxt (st_nxt)
  );

  // Control and state registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      st_r        <= '0;
    end else begin
      in_valid_r  <= in_valid_nxt;
      out_valid_r <= out_valid_nxt;
      if (advance) begin
        st_r <= st_nxt;
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    if (in_accept) begin
      in_hdr_r.header_word   <= in_if.header_word;
      in_hdr_r.frag_start    <= in_if.frag_start;
      in_hdr_r.frag_len      <= in_if.frag_len;
      in_hdr_r.payload_bytes <= in_if.payload_bytes;
    end
    if (advance) begin
      out_res_r <= res_nxt;
    end
  end

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.frag_size <= FRAG_SIZE_RST;
      cfg_r.max_msg   <= MAX_MSG_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_FRAG_SIZE: cfg_r.frag_size <= cfg_data[LEN_W-1:0];
        CFG_MAX_MSG:   cfg_r.max_msg   <= cfg_data[MAX_W-1:0];
        default:       cfg_r           <= cfg_r;
      endcase
    end
  end

  // Result channel outputs.
  assign out_if.valid          = out_valid_r;
  assign out_if.verdict        = out_res_r.verdict;
  assign out_if.seq_number     = out_res_r.seq_number;
  assign out_if.dropped_count  = out_res_r.dropped_count;
  assign out_if.write_offset   = out_res_r.write_offset;
  assign out_if.copy_length    = out_res_r.copy_length;
  assign out_if.message_length = out_res_r.message_length;

`ifndef ASSERT_OFF
  // The reassembly fill never runs past the buffer.
  a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
    {1'b0, st_r.fill} <= (FILL_W+1)'(BUFFER_BYTES))
    else $error("reassembly fill exceeds buffer size");

  // A finished message clears the fill and becomes the last accepted sequence.
  a_reasm_update: assert property (@(posedge clk) disable iff (!rst_n)
    advance && (res_nxt.verdict == VERDICT_REASM) |=>
      (st_r.fill == '0) && (st_r.last_seq == out_res_r.seq_number))
    else $error("reassembled message did not update state");

  // Only stored fragments carry a copy length or write offset.
  a_copy_only_stored: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && (out_res_r.verdict != VERDICT_REASM) &&
    (out_res_r.verdict != VERDICT_MORE) && (out_res_r.verdict != VERDICT_TOO_LONG)
    |-> (out_res_r.copy_length == '0) && (out_res_r.write_offset == '0))
    else $error("copy reported for an unstored header");

  // A stale sequence reports no dropped numbers and leaves the state alone.
  a_stale_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    advance && (res_nxt.verdict == VERDICT_STALE) |->
      (res_nxt.dropped_count == '0) && (st_nxt == st_r))
    else $error("stale header changed state or reported drops");
`endif

endmodule

/* tb/sfr_checker.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Sequenced fragment receiver result checker
// Watches the header and result channels and the register writes, works out
// the verdict for every accepted header, and compares each result with the
// oldest verdict still due.
// ----------------------------------------------------------------------------
module sfr_checker
  import sfr_pkg::*;
#(
  parameter int BUFFER_BYTES = 16384
) (
  input  logic                 clk,
  input  logic                 rst_n,
  sfr_hdr_if                   hdr,
  sfr_res_if                   res,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_data,
  output int unsigned          fail_count,
  output int unsigned          awaiting
);

  // Register copies and sequence/reassembly state as this checker sees them.
  cfg_t   limits;
  state_t track;
  res_t   verdicts_due[$];

  // Decide one header against the tracked state and update that state.
  task automatic judge_header(input hdr_t h, output res_t r);
    logic [SEQ_W-1:0] seq;
    logic             is_frag;
    int               start;
    int               len;
    int               avail;
    seq     = h.header_word[SEQ_W-1:0];
    is_frag = h.header_word[31];
    start   = $signed(h.frag_start);
    len     = $signed(h.frag_len);
    avail   = int'(h.payload_bytes);
    r            = '0;
    r.seq_number = seq;
    if (seq <= track.last_seq) begin
      r.verdict = VERDICT_STALE;
    end else begin
      r.dropped_count = seq - track.last_seq - 31'd1;
      if (!is_frag) begin
        r.verdict      = VERDICT_WHOLE;
        track.last_seq = seq;
      end else begin
        // A fragment of a different sequence restarts reassembly first.
        if (seq != track.asm_seq) begin
          track.asm_seq = seq;
          track.fill    = '0;
        end
        if (start != int'(track.fill)) begin
          r.verdict = VERDICT_GAP;
        end else if (len < 0 || len > avail ||
                     int'(track.fill) + len > BUFFER_BYTES) begin
          r.verdict = VERDICT_BAD_LEN;
        end else begin
          r.write_offset = track.fill[OFF_W-1:0];
          r.copy_length  = len[LEN_W-1:0];
          track.fill     = track.fill + len[FILL_W-1:0];
          if (len == int'(limits.frag_size)) begin
            r.verdict = VERDICT_MORE;
          end else if (track.fill > FILL_W'(limits.max_msg)) begin
            r.verdict = VERDICT_TOO_LONG;
          end else begin
            r.verdict        = VERDICT_REASM;
            r.message_length = track.fill[OFF_W-1:0];
            track.fill       = '0;
            track.last_seq   = seq;
          end
        end
      end
    end
  endtask

  // Follow both channels at every rising edge.
  always @(posedge clk) begin
    hdr_t h;
    res_t want;
    res_t got;
    if (!rst_n) begin
      track          = '0;
      limits.frag_size = FRAG_SIZE_RST;
      limits.max_msg   = MAX_MSG_RST;
      fail_count     = 0;
      verdicts_due.delete();
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          CFG_FRAG_SIZE: limits.frag_size = cfg_data[LEN_W-1:0];
          CFG_MAX_MSG:   limits.max_msg   = cfg_data[MAX_W-1:0];
          default: ;
        endcase
      end
      if (hdr.valid && hdr.ready) begin
        h.header_word   = hdr.header_word;
        h.frag_start    = hdr.frag_start;
        h.frag_len      = hdr.frag_len;
        h.payload_bytes = hdr.payload_bytes;
        judge_header(h, want);
        verdicts_due.push_back(want);
      end
      if (res.valid && res.ready) begin
        got.verdict        = verdict_t'(res.verdict);
        got.seq_number     = res.seq_number;
        got.dropped_count  = res.dropped_count;
        got.write_offset   = res.write_offset;
        got.copy_length    = res.copy_length;
        got.message_length = res.message_length;
        if (verdicts_due.size() == 0) begin
          if (fail_count < 10)
            $display("%0t: result with no header pending: verdict %0d seq %0h", $realtime,
                     got.verdict, got.seq_number);
          fail_count++;
        end else begin
          want = verdicts_due.pop_front();
          if (got !== want) begin
            if (fail_count < 10) begin
              $display("%0t: result mismatch, expected verdict %0d seq %0h drop %0h off %0d",
                       $realtime, want.verdict, want.seq_number, want.dropped_count,
                       want.write_offset);
              $display("      copy %0d len %0d; got verdict %0d seq %0h drop %0h off %0d",
                       want.copy_length, want.message_length, got.verdict,
                       got.seq_number, got.dropped_count, got.write_offset);
              $display("      copy %0d len %0d", got.copy_length, got.message_length);
            end
            fail_count++;
          end
        end
      end
    end
    awaiting = verdicts_due.size();
  end

endmodule

/* tb/tb.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Sequenced fragment receiver testbench
// Drives directed and random datagram headers through several register
// settings with random idling on both channels, then reports the outcome
// of the result checker.
// ----------------------------------------------------------------------------
module tb;
  import sfr_pkg::*;

  localparam int BUFFER_BYTES = 16384;
  localparam int LIMIT_CYCLES = 400000;
  localparam int HOLD_CYCLES  = 300;

  // Ways of spoiling one fragment of an otherwise well-formed message.
  typedef enum int {
    FLAW_NONE,
    FLAW_GAP,
    FLAW_SHORT_PAYLOAD,
    FLAW_NEG_LEN
  } flaw_e;

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = CFG_FRAG_SIZE;
  logic [CFG_W-1:0]     cfg_data = '0;
  int unsigned          fail_count;
  int unsigned          awaiting;
  int unsigned          cycles = 0;
  bit                   calm = 1'b0;
  bit                   hold_request = 1'b0;
  logic [SEQ_W-1:0]     seq_base = '0;
  int                   frag_now = 1300;

  sfr_hdr_if hdr_ch ();
  sfr_res_if res_ch ();

  sequenced_fragment_receiver #(.BUFFER_BYTES(BUFFER_BYTES)) u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_if     (hdr_ch),
    .out_if    (res_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  sfr_checker #(.BUFFER_BYTES(BUFFER_BYTES)) u_check (
    .clk        (clk),
    .rst_n      (rst_n),
    .hdr        (hdr_ch),
    .res        (res_ch),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .fail_count (fail_count),
    .awaiting   (awaiting)
  );

  // 4 ns clock.
  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Give up on a hung run.
  always @(posedge clk) begin
    cycles++;
    if (cycles == LIMIT_CYCLES) begin
      $display("end of test: mismatches");
      $finish;
    end
  end

  // Result side: random stalls, plus one long hold-off when asked for.
  initial begin
    int stall;
    bit held;
    held = 1'b0;
    res_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_request && !held) begin
        res_ch.ready = 1'b0;
        repeat (HOLD_CYCLES - 1) @(negedge clk);
        held = 1'b1;
      end else if (!calm && $urandom_range(0, 9) == 0) begin
        res_ch.ready = 1'b0;
        stall = $urandom_range(1, 16);
        repeat (stall - 1) @(negedge clk);
      end else begin
        res_ch.ready = 1'b1;
      end
    end
  end

  function automatic hdr_t make_header(input bit frag, input logic [SEQ_W-1:0] seq,
                                       input int start, input int len, input int avail);
    hdr_t h;
    h.header_word   = {frag, seq};
    h.frag_start    = start[15:0];
    h.frag_len      = len[15:0];
    h.payload_bytes = avail[LEN_W-1:0];
    return h;
  endfunction

  // Offer one header request, after an occasional gap, and wait for it to go.
  task automatic offer_header(input hdr_t h);
    int gap;
    @(negedge clk);
    if (!calm && $urandom_range(0, 9) == 0) begin
      hdr_ch.valid = 1'b0;
      gap = $urandom_range(1, 16);
      repeat (gap) @(negedge clk);
    end
    hdr_ch.valid         = 1'b1;
    hdr_ch.header_word   = h.header_word;
    hdr_ch.frag_start    = h.frag_start;
    hdr_ch.frag_len      = h.frag_len;
    hdr_ch.payload_bytes = h.payload_bytes;
    do @(posedge clk); while (!hdr_ch.ready);
  endtask

  // Stop offering and wait until every result has come back.
  task automatic drain_results();
    @(negedge clk);
    hdr_ch.valid = 1'b0;
    while (awaiting != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  // Write both registers while the block is idle.
  task automatic set_limits(input int frag_size, input int max_msg);
    drain_results();
    cfg_we    = 1'b1;
    cfg_index = CFG_FRAG_SIZE;
    cfg_data  = CFG_W'(frag_size);
    @(negedge clk);
    cfg_index = CFG_MAX_MSG;
    cfg_data  = CFG_W'(max_msg);
    @(negedge clk);
    cfg_we    = 1'b0;
    frag_now  = frag_size;
  endtask

  // Mostly well-formed fragment messages, some whole datagrams and some noise.
  task automatic run_traffic(input int unsigned items);
    int unsigned      sent;
    int               pick;
    int               nfull;
    int               offset;
    int               start;
    int               len;
    int               avail;
    int               k;
    flaw_e            flaw;
    logic [SEQ_W-1:0] seq;
    sent = 0;
    while (sent < items) begin
      pick = $urandom_range(0, 99);
      if (pick < 15) begin
        seq_base = seq_base + SEQ_W'($urandom_range(1, 3));
        offer_header(make_header(1'b0, seq_base, $urandom, $urandom, $urandom_range(0, 2047)));
        sent++;
      end else if (pick < 27) begin
        seq = SEQ_W'($urandom_range(0, seq_base + 1));
        offer_header(make_header(1'($urandom_range(0, 1)), seq, $urandom, $urandom,
                                 $urandom_range(0, 2047)));
        sent++;
      end else begin
        seq_base = seq_base + SEQ_W'($urandom_range(1, 2));
        if (frag_now >= 1024 && $urandom_range(0, 19) == 0)
          nfull = BUFFER_BYTES / frag_now + $urandom_range(0, 1);
        else
          nfull = $urandom_range(0, 4);
        offset = 0;
        for (k = 0; k <= nfull; k++) begin
          if (k < nfull) begin
            len = frag_now;
          end else begin
            if ($urandom_range(0, 1) == 0)
              len = $urandom_range(0, frag_now);
            else
              len = $urandom_range(0, 2047);
            // The last fragment must be short of a full one to end the message.
            if (len == frag_now)
              len = frag_now - 1;
          end
          avail = $urandom_range(len, 2047);
          start = offset;
          pick  = $urandom_range(0, 29);
          flaw  = (pick == 0) ? FLAW_GAP :
                  (pick == 1) ? FLAW_SHORT_PAYLOAD :
                  (pick == 2) ? FLAW_NEG_LEN : FLAW_NONE;
          case (flaw)
            FLAW_GAP:           start = offset + $urandom_range(1, 50);
            FLAW_SHORT_PAYLOAD: if (len > 0) avail = $urandom_range(0, len - 1);
            FLAW_NEG_LEN:       len = -int'($urandom_range(1, 32768));
            default: ;
          endcase
          offer_header(make_header(1'b1, seq_base, start, len, avail));
          sent++;
          if (flaw == FLAW_NONE && offset + len <= BUFFER_BYTES)
            offset += len;
        end
      end
    end
  endtask

  // Reset, then the phases of stimulus, then the verdict.
  initial begin
    int k;
    hdr_ch.valid         = 1'b0;
    hdr_ch.header_word   = '0;
    hdr_ch.frag_start    = '0;
    hdr_ch.frag_len      = '0;
    hdr_ch.payload_bytes = '0;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // Sequence checks and reassembly corner cases at the reset settings.
    offer_header(make_header(1'b0, 31'd1, 0, 0, 0));
    offer_header(make_header(1'b0, 31'd1, 5, 5, 5));
    offer_header(make_header(1'b0, 31'd0, 0, 0, 0));
    offer_header(make_header(1'b0, 31'd5, 0, 0, 0));
    offer_header(make_header(1'b1, 31'd6, 0, 1300, 1400));
    offer_header(make_header(1'b1, 31'd6, 0, 100, 2047));
    offer_header(make_header(1'b1, 31'd6, 1300, -1, 2047));
    offer_header(make_header(1'b1, 31'd6, 1300, 600, 500));
    offer_header(make_header(1'b1, 31'd6, 1300, 200, 2047));
    offer_header(make_header(1'b1, 31'd7, -32768, 0, 0));
    offer_header(make_header(1'b1, 31'd8, 0, 0, 0));
    offer_header(make_header(1'b1, 31'd9, 0, 32767, 2047));
    offer_header(make_header(1'b1, 31'd9, 0, 1300, 1300));
    offer_header(make_header(1'b1, 31'd10, 0, 10, 10));
    offer_header(make_header(1'b1, 31'h7FFF_FFFF, -1, -1, 2047));
    seq_base = 31'd10;
    run_traffic(100);

    // Largest fragments: fill the buffer exactly, and overrun it by one byte.
    set_limits(2047, 16384);
    seq_base = 31'd20000;
    for (k = 0; k < 8; k++)
      offer_header(make_header(1'b1, seq_base, k * 2047, 2047, 2047));
    offer_header(make_header(1'b1, seq_base, 16376, 9, 9));
    offer_header(make_header(1'b1, seq_base, 16376, 8, 100));
    run_traffic(80);

    // Smallest fragment size, no message allowed to grow at all.
    set_limits(1, 0);
    seq_base = SEQ_W'(32'h4000_0000 + $urandom_range(0, 999));
    run_traffic(100);

    // Tight limit; the result side holds off for a long stretch at the start.
    set_limits(200, 600);
    hold_request = 1'b1;
    run_traffic(150);

    // Largest fragments and the loosest limit, sequences near the top.
    set_limits(2047, 65535);
    seq_base = SEQ_W'(32'h7FF0_0000 + $urandom_range(0, 999));
    run_traffic(100);

    // Closing stretch without idling on either side.
    set_limits(64, 1000);
    calm = 1'b1;
    run_traffic(150);
    offer_header(make_header(1'b0, 31'h7FFF_FFFF, -1, -1, 2047));

    drain_results();
    repeat (8) @(negedge clk);
    if (fail_count == 0)
      $display("end of test: clean");
    else
      $display("end of test: mismatches");
    $finish;
  end

endmodule
